// ===== rtl/glrd_pkg.sv =====
// Shared types, constants and helpers of the glyph run-length bitmap decoder.
// Used by glrd_ctrl, glrd_dp and glyph_rle_bitmap_decoder; depends on nothing.
package glrd_pkg;

  localparam int NUM_CFG   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 4;
  localparam int BYTE_BITS = 8;
  localparam int MAX_RES   = 17;
  localparam int RES_CNT_W = 5;
  localparam int DIV_STEPS = 9;
  localparam int DIV_CNT_W = 4;
  localparam int TDATA_W   = 72;

  localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] =
    '{4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_RUN = 3'd0,
    CFG_ONE_RUN  = 3'd1,
    CFG_WIDTH    = 3'd2,
    CFG_HEIGHT   = 3'd3,
    CFG_XOFF     = 3'd4,
    CFG_YOFF     = 3'd5,
    CFG_ADVANCE  = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_WIDTH  = 3'd0,
    PH_HEIGHT = 3'd1,
    PH_XOFF   = 3'd2,
    PH_YOFF   = 3'd3,
    PH_ADV    = 3'd4,
    PH_ZERO   = 3'd5,
    PH_ONE    = 3'd6,
    PH_REPEAT = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_RUN    = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    LEN_FIELD = 2'd0,
    LEN_ZERO  = 2'd1,
    LEN_ONE   = 2'd2
  } len_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIELD,
    ST_HDR,
    ST_FIN,
    ST_REP0,
    ST_REP1,
    ST_DIV,
    ST_POS,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic     start_clr;
    logic     load;
    logic     take;
    logic     phase_ld;
    phase_t   phase_val;
    logic     emit;
    kind_t    emit_kind;
    logic     emit_color;
    len_src_t len_src;
    logic     div_start;
    logic     div_step;
    logic     pos_upd;
    logic     finish;
    logic     flush;
  } glrd_cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   fill_short;
    logic   fld_zero;
    logic   width_zero;
    logic   row_done;
    logic   zlen_zero;
    logic   olen_zero;
    logic   div_last;
    logic   pend_valid;
    logic   emit_ok;
    logic   out_free;
    logic   glyph_done;
  } glrd_stat_t;

  typedef struct packed {
    kind_t      kind;
    logic       color;
    logic [7:0] len;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] width;
    logic [7:0] height;
    logic [7:0] offx;
    logic [7:0] offy;
    logic [7:0] adv;
  } glrd_res_t;

  function automatic logic [CFG_W-1:0] clamp_bits(input logic [CFG_W-1:0] r);
    logic [CFG_W-1:0] w;
    w = r;
    if (r == 4'd0) begin
      w = 4'd1;
    end else if (r > 4'd8) begin
      w = 4'd8;
    end
    return w;
  endfunction

endpackage

// ===== rtl/glrd_ctrl.sv =====
// Controller state machine of the glyph run-length bitmap decoder.
// Sequences field extraction, result emission and row wrapping; uses glrd_pkg.
module glrd_ctrl
  import glrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_start,
  output logic       in_tready,
  input  glrd_stat_t stat,
  output glrd_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        ret_rep1_r, ret_rep1_nxt;
  logic        run_go;
  logic        rep0_skip;
  logic        rep1_skip;

  assign run_go    = !stat.fld_zero && !stat.width_zero;
  assign rep0_skip = stat.zlen_zero || stat.width_zero;
  assign rep1_skip = stat.olen_zero || stat.width_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ret_rep1_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_rep1_r <= ret_rep1_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ret_rep1_nxt = ret_rep1_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && (in_start || !stat.glyph_done)) begin
          state_nxt = ST_FIELD;
        end
      end
      ST_FIELD: begin
        if (stat.fill_short) begin
          state_nxt = ST_FLUSH;
        end else begin
          unique case (stat.phase)
            PH_WIDTH, PH_HEIGHT, PH_XOFF, PH_YOFF: state_nxt = ST_FIELD;
            PH_ADV: state_nxt = ST_HDR;
            PH_ZERO, PH_ONE: begin
              if (run_go && stat.emit_ok) begin
                state_nxt    = ST_DIV;
                ret_rep1_nxt = 1'b0;
              end
            end
            PH_REPEAT: begin
              if (!stat.fld_zero) begin
                state_nxt = ST_REP0;
              end else if (stat.row_done) begin
                state_nxt = ST_FIN;
              end
            end
          endcase
        end
      end
      ST_HDR: begin
        if (stat.emit_ok) begin
          state_nxt = stat.width_zero ? ST_FIN : ST_FIELD;
        end
      end
      ST_FIN: begin
        if (stat.emit_ok) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_REP0: begin
        if (rep0_skip) begin
          state_nxt = ST_REP1;
        end else if (stat.emit_ok) begin
          state_nxt    = ST_DIV;
          ret_rep1_nxt = 1'b1;
        end
      end
      ST_REP1: begin
        if (rep1_skip) begin
          state_nxt = ST_FIELD;
        end else if (stat.emit_ok) begin
          state_nxt    = ST_DIV;
          ret_rep1_nxt = 1'b0;
        end
      end
      ST_DIV: begin
        if (stat.div_last) begin
          state_nxt = ST_POS;
        end
      end
      ST_POS: begin
        state_nxt = ret_rep1_r ? ST_REP1 : ST_FIELD;
      end
      ST_FLUSH: begin
        if (!stat.pend_valid || stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start_clr = in_start;
          cmd.load      = in_start || !stat.glyph_done;
        end
      end
      ST_FIELD: begin
        if (!stat.fill_short) begin
          unique case (stat.phase)
            PH_WIDTH: begin
              cmd.take      = 1'b1;
              cmd.phase_ld  = 1'b1;
              cmd.phase_val = PH_HEIGHT;
            end
            PH_HEIGHT: begin
              cmd.take      = 1'b1;
              cmd.phase_ld  = 1'b1;
              cmd.phase_val = PH_XOFF;
            end
            PH_XOFF: begin
              cmd.take      = 1'b1;
              cmd.phase_ld  = 1'b1;
              cmd.phase_val = PH_YOFF;
            end
            PH_YOFF: begin
              cmd.take      = 1'b1;
              cmd.phase_ld  = 1'b1;
              cmd.phase_val = PH_ADV;
            end
            PH_ADV: cmd.take = 1'b1;
            PH_ZERO, PH_ONE: begin
              if (!run_go || stat.emit_ok) begin
                cmd.take      = 1'b1;
                cmd.phase_ld  = 1'b1;
                cmd.phase_val = (stat.phase == PH_ZERO) ? PH_ONE : PH_REPEAT;
                if (run_go) begin
                  cmd.emit       = 1'b1;
                  cmd.emit_kind  = KIND_RUN;
                  cmd.emit_color = (stat.phase == PH_ONE);
                  cmd.len_src    = LEN_FIELD;
                  cmd.div_start  = 1'b1;
                end
              end
            end
            PH_REPEAT: begin
              cmd.take = 1'b1;
              if (stat.fld_zero && !stat.row_done) begin
                cmd.phase_ld  = 1'b1;
                cmd.phase_val = PH_ZERO;
              end
            end
          endcase
        end
      end
      ST_HDR: begin
        if (stat.emit_ok) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_HEADER;
          if (!stat.width_zero) begin
            cmd.phase_ld  = 1'b1;
            cmd.phase_val = PH_ZERO;
          end
        end
      end
      ST_FIN: begin
        if (stat.emit_ok) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_END;
          cmd.finish    = 1'b1;
        end
      end
      ST_REP0: begin
        if (!rep0_skip && stat.emit_ok) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = KIND_RUN;
          cmd.emit_color = 1'b0;
          cmd.len_src    = LEN_ZERO;
          cmd.div_start  = 1'b1;
        end
      end
      ST_REP1: begin
        if (!rep1_skip && stat.emit_ok) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = KIND_RUN;
          cmd.emit_color = 1'b1;
          cmd.len_src    = LEN_ONE;
          cmd.div_start  = 1'b1;
        end
      end
      ST_DIV:   cmd.div_step = 1'b1;
      ST_POS:   cmd.pos_upd  = 1'b1;
      ST_FLUSH: cmd.flush    = !stat.pend_valid || stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/glrd_dp.sv =====
// Datapath of the glyph run-length bitmap decoder: bit store, glyph registers,
// restoring divider for row wrapping and the result registers; uses glrd_pkg.
module glrd_dp
  import glrd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [7:0]           in_byte,
  input  glrd_cmd_t            cmd,
  output glrd_stat_t           stat,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic                 out_last,
  output glrd_res_t            out_res
);

  logic [CFG_W-1:0] cfg_r [NUM_CFG];

  logic [15:0]          store_r, store_nxt;
  logic [4:0]           fill_r, fill_nxt;
  phase_t               phase_r, phase_nxt;
  logic                 done_r, done_nxt;
  logic [7:0]           width_r, width_nxt;
  logic [7:0]           height_r, height_nxt;
  logic [7:0]           offx_r, offx_nxt;
  logic [7:0]           offy_r, offy_nxt;
  logic [7:0]           adv_r, adv_nxt;
  logic [7:0]           col_r, col_nxt;
  logic [7:0]           row_r, row_nxt;
  logic [7:0]           zlen_r, zlen_nxt;
  logic [7:0]           olen_r, olen_nxt;
  logic [8:0]           div_num_r, div_num_nxt;
  logic [7:0]           div_rem_r, div_rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  glrd_res_t            pend_r, pend_nxt;
  logic                 pend_v_r, pend_v_nxt;
  glrd_res_t            out_r, out_nxt;
  logic                 out_v_r, out_v_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [RES_CNT_W-1:0] res_cnt_r, res_cnt_nxt;

  logic [CFG_W-1:0] fld_w;
  logic [15:0]      fld_mask;
  logic [7:0]       fld_v;
  logic [7:0]       fld_bias;
  logic [7:0]       fld_biased;
  logic [7:0]       run_len;
  logic [8:0]       div_trial;
  logic [8:0]       div_diff;
  logic             div_ge;
  logic [9:0]       row_sum;
  logic [15:0]      base_store;
  logic [4:0]       base_fill;
  logic             cap_hit;
  logic             out_free;
  glrd_res_t        new_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_r[i] <= CFG_RESET[i];
      end
    end else if (cfg_we && (cfg_index <= CFG_ADVANCE)) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  always_comb begin
    unique case (phase_r)
      PH_WIDTH:  fld_w = clamp_bits(cfg_r[CFG_WIDTH]);
      PH_HEIGHT: fld_w = clamp_bits(cfg_r[CFG_HEIGHT]);
      PH_XOFF:   fld_w = clamp_bits(cfg_r[CFG_XOFF]);
      PH_YOFF:   fld_w = clamp_bits(cfg_r[CFG_YOFF]);
      PH_ADV:    fld_w = clamp_bits(cfg_r[CFG_ADVANCE]);
      PH_ZERO:   fld_w = clamp_bits(cfg_r[CFG_ZERO_RUN]);
      PH_ONE:    fld_w = clamp_bits(cfg_r[CFG_ONE_RUN]);
      PH_REPEAT: fld_w = 4'd1;
    endcase
  end

  assign fld_mask   = ~(16'hFFFF << fld_w);
  assign fld_v      = store_r[7:0] & fld_mask[7:0];
  assign fld_bias   = 8'd1 << (fld_w - 4'd1);
  assign fld_biased = fld_v - fld_bias;

  always_comb begin
    case (cmd.len_src)
      LEN_FIELD: run_len = fld_v;
      LEN_ZERO:  run_len = zlen_r;
      LEN_ONE:   run_len = olen_r;
      default:   run_len = fld_v;
    endcase
  end

  assign div_trial = {div_rem_r, div_num_r[8]};
  assign div_ge    = div_trial >= {1'b0, width_r};
  assign div_diff  = div_trial - {1'b0, width_r};
  assign row_sum   = {2'b00, row_r} + {1'b0, div_num_r};

  assign base_store = cmd.start_clr ? 16'd0 : store_r;
  assign base_fill  = cmd.start_clr ? 5'd0 : fill_r;

  assign cap_hit  = (res_cnt_r == RES_CNT_W'(MAX_RES));
  assign out_free = !out_v_r || out_tready;

  always_comb begin
    new_res        = '0;
    new_res.kind   = cmd.emit_kind;
    new_res.width  = width_r;
    new_res.height = height_r;
    new_res.offx   = offx_r;
    new_res.offy   = offy_r;
    new_res.adv    = adv_r;
    if (cmd.emit_kind == KIND_RUN) begin
      new_res.color = cmd.emit_color;
      new_res.len   = run_len;
      new_res.col   = col_r;
      new_res.row   = row_r;
    end
  end

  always_comb begin
    store_nxt    = store_r;
    fill_nxt     = fill_r;
    phase_nxt    = phase_r;
    done_nxt     = done_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    offx_nxt     = offx_r;
    offy_nxt     = offy_r;
    adv_nxt      = adv_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    zlen_nxt     = zlen_r;
    olen_nxt     = olen_r;
    div_num_nxt  = div_num_r;
    div_rem_nxt  = div_rem_r;
    div_cnt_nxt  = div_cnt_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    out_nxt      = out_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_last_nxt = out_last_r;
    res_cnt_nxt  = res_cnt_r;

    if (cmd.start_clr) begin
      phase_nxt  = PH_WIDTH;
      done_nxt   = 1'b0;
      width_nxt  = 8'd0;
      height_nxt = 8'd0;
      offx_nxt   = 8'd0;
      offy_nxt   = 8'd0;
      adv_nxt    = 8'd0;
      col_nxt    = 8'd0;
      row_nxt    = 8'd0;
      zlen_nxt   = 8'd0;
      olen_nxt   = 8'd0;
    end
    if (cmd.load) begin
      store_nxt   = base_store | ({8'd0, in_byte} << base_fill[3:0]);
      fill_nxt    = base_fill + 5'(BYTE_BITS);
      res_cnt_nxt = '0;
    end

    if (cmd.take) begin
      store_nxt = store_r >> fld_w;
      fill_nxt  = fill_r - {1'b0, fld_w};
      case (phase_r)
        PH_WIDTH:  width_nxt  = fld_v;
        PH_HEIGHT: height_nxt = fld_v;
        PH_XOFF:   offx_nxt   = fld_biased;
        PH_YOFF:   offy_nxt   = fld_biased;
        PH_ADV:    adv_nxt    = fld_biased;
        PH_ZERO:   zlen_nxt   = fld_v;
        PH_ONE:    olen_nxt   = fld_v;
        default: ;
      endcase
    end
    if (cmd.phase_ld) begin
      phase_nxt = cmd.phase_val;
    end
    if (cmd.finish) begin
      done_nxt  = 1'b1;
      store_nxt = 16'd0;
      fill_nxt  = 5'd0;
    end

    if (cmd.div_start) begin
      div_num_nxt = {1'b0, col_r} + {1'b0, run_len};
      div_rem_nxt = 8'd0;
      div_cnt_nxt = '0;
    end
    if (cmd.div_step) begin
      div_rem_nxt = div_ge ? div_diff[7:0] : div_trial[7:0];
      div_num_nxt = {div_num_r[7:0], div_ge};
      div_cnt_nxt = div_cnt_r + 1'b1;
    end
    if (cmd.pos_upd) begin
      col_nxt = div_rem_r;
      row_nxt = (row_sum > 10'd255) ? 8'hFF : row_sum[7:0];
    end

    if (cmd.emit && !cap_hit) begin
      if (pend_v_r) begin
        out_nxt      = pend_r;
        out_last_nxt = 1'b0;
        out_v_nxt    = 1'b1;
      end
      pend_nxt    = new_res;
      pend_v_nxt  = 1'b1;
      res_cnt_nxt = res_cnt_r + 1'b1;
    end
    if (cmd.flush && pend_v_r) begin
      out_nxt      = pend_r;
      out_last_nxt = 1'b1;
      out_v_nxt    = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r   <= 16'd0;
      fill_r    <= 5'd0;
      phase_r   <= PH_WIDTH;
      done_r    <= 1'b1;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      res_cnt_r <= '0;
      div_cnt_r <= '0;
    end else begin
      store_r   <= store_nxt;
      fill_r    <= fill_nxt;
      phase_r   <= phase_nxt;
      done_r    <= done_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
      res_cnt_r <= res_cnt_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    width_r    <= width_nxt;
    height_r   <= height_nxt;
    offx_r     <= offx_nxt;
    offy_r     <= offy_nxt;
    adv_r      <= adv_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    zlen_r     <= zlen_nxt;
    olen_r     <= olen_nxt;
    div_num_r  <= div_num_nxt;
    div_rem_r  <= div_rem_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    stat            = '0;
    stat.phase      = phase_r;
    stat.fill_short = fill_r < {1'b0, fld_w};
    stat.fld_zero   = (fld_v == 8'd0);
    stat.width_zero = (width_r == 8'd0);
    stat.row_done   = (row_r >= height_r);
    stat.zlen_zero  = (zlen_r == 8'd0);
    stat.olen_zero  = (olen_r == 8'd0);
    stat.div_last   = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
    stat.pend_valid = pend_v_r;
    stat.emit_ok    = cap_hit || !pend_v_r || out_free;
    stat.out_free   = out_free;
    stat.glyph_done = done_r;
  end

  assign out_tvalid = out_v_r;
  assign out_last   = out_last_r;
  assign out_res    = out_r;

endmodule

// ===== rtl/glyph_rle_bitmap_decoder.sv =====
// Top level of the glyph run-length bitmap decoder: stream ports and the
// configuration port; instantiates glrd_ctrl and glrd_dp, uses glrd_pkg.
//
// A byte is taken only while the block is idle, and the block then works on it alone.
// After accepting it, the block extracts each bit field in turn and emits the header and
// end results; every nonzero run then goes through the nine steps of the restoring divider
// that wraps the position at the glyph width and one position update, and so does each
// nonzero run of a replayed pair. Last the block finds the store short of the next field
// and hands over the byte's last result; the short-store check is absent when the glyph
// ends. Every result passes through a holding register and an output register, so the
// next byte is accepted while the last result still waits; a stalled output stops the
// decoder at its next result and at the hand-over.
module glyph_rle_bitmap_decoder
  import glrd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // glyph_byte
  input  logic [0:0]           in_tuser,   // glyph_start
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // run_color, run_length, run_column, run_row, glyph_width, glyph_height,
  // offset_x, offset_y, advance_x, zero fill
  output logic [TDATA_W-1:0]   out_tdata,
  output logic [1:0]           out_tuser,  // result_kind
  output logic                 out_tlast
);

  glrd_cmd_t  cmd;
  glrd_stat_t stat;
  glrd_res_t  res;

  glrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_start  (in_tuser[0]),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  glrd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_last   (out_tlast),
    .out_res    (res)
  );

  assign out_tdata = {7'd0, res.adv, res.offy, res.offx, res.height, res.width,
                      res.row, res.col, res.len, res.color};
  assign out_tuser = res.kind;

`ifndef SYNTH
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !stat.pend_valid)
    else $error("Input taken while a result is still held back.");

  a_emit_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.emit_ok)
    else $error("Result emitted without room in the result registers.");

  a_div_then_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && stat.div_last) |=> cmd.pos_upd)
    else $error("Division finished without a position update.");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for glyph_rle_bitmap_decoder: directed bytes, then random glyphs,
// under random idling on both streams. Each result is checked against an in-bench decoder or
// fixed expected results. Depends on rtl/glrd_pkg.sv and the decoder RTL only.
`timescale 1ns / 100ps

module tb_top;
  import glrd_pkg::*;

  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 330;
  localparam int REPORT_LIMIT = 10;
  localparam int SETTING_SPAN = 40;

  typedef struct packed {
    kind_t      kind;
    logic       color;
    logic [7:0] len;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] width;
    logic [7:0] height;
    logic [7:0] offx;
    logic [7:0] offy;
    logic [7:0] adv;
    logic       last;
  } glyph_res_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t    op;
    logic [7:0] data;
    logic       start;
    cfg_idx_t   idx;
    logic [3:0] value;
    logic       typed;
    logic [1:0] n_typed;
    glyph_res_t r0;
    glyph_res_t r1;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic [0:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [TDATA_W-1:0]   out_tdata;
  logic [1:0]           out_tuser;
  logic                 out_tlast;

  glyph_rle_bitmap_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Decoder state as seen by the bench.
  logic [3:0]  cfg_shadow [NUM_CFG];
  logic [15:0] p_store;
  logic [4:0]  p_fill;
  phase_t      p_phase;
  logic [7:0]  p_width, p_height, p_offx, p_offy, p_adv;
  logic [7:0]  p_col, p_row, p_zlen, p_olen;
  logic        p_done;

  glyph_res_t  byte_results [$];
  glyph_res_t  pending_results [$];
  plan_row_t   directed_plan [$];

  bit full_rate;
  bit dirty;
  int n_fail, n_counted, n_ignored, n_glyphs, n_results, n_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("glyph_rle_bitmap_decoder test failed");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= full_rate ? 1'b1 : ($urandom_range(0, 99) >= 27);
  end

  function automatic int unsigned field_width(cfg_idx_t i);
    int unsigned w;
    w = cfg_shadow[i];
    if (w < 1) w = 1;
    if (w > 8) w = 8;
    return w;
  endfunction

  function automatic int unsigned phase_width();
    case (p_phase)
      PH_WIDTH:  return field_width(CFG_WIDTH);
      PH_HEIGHT: return field_width(CFG_HEIGHT);
      PH_XOFF:   return field_width(CFG_XOFF);
      PH_YOFF:   return field_width(CFG_YOFF);
      PH_ADV:    return field_width(CFG_ADVANCE);
      PH_ZERO:   return field_width(CFG_ZERO_RUN);
      PH_ONE:    return field_width(CFG_ONE_RUN);
      default:   return 1;
    endcase
  endfunction

  function automatic void add_result(kind_t k, logic c, int unsigned len,
                                     logic [7:0] col, logic [7:0] row);
    glyph_res_t r;
    if (byte_results.size() >= MAX_RES) return;
    r.kind   = k;
    r.color  = c;
    r.len    = 8'(len);
    r.col    = col;
    r.row    = row;
    r.width  = p_width;
    r.height = p_height;
    r.offx   = p_offx;
    r.offy   = p_offy;
    r.adv    = p_adv;
    r.last   = 1'b0;
    byte_results.insert(byte_results.size(), r);
  endfunction

  function automatic void queue_expected(glyph_res_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void paint_run(logic c, int unsigned len);
    int unsigned total, rows;
    if (len == 0 || p_width == 0) return;
    add_result(KIND_RUN, c, len, p_col, p_row);
    total = p_col + len;
    rows  = p_row + total / p_width;
    p_col = 8'(total % p_width);
    p_row = (rows > 255) ? 8'd255 : 8'(rows);
  endfunction

  function automatic void close_glyph();
    add_result(KIND_END, 1'b0, 0, 8'd0, 8'd0);
    p_done  = 1'b1;
    p_store = '0;
    p_fill  = '0;
  endfunction

  function automatic logic [7:0] unbias(int unsigned v, int unsigned w);
    return 8'(v - (1 << (w - 1)));
  endfunction

  // Returns 0 when the byte is ignored because no glyph is open.
  function automatic logic decode_glyph_byte(logic [7:0] b, logic st);
    int unsigned w, v;
    byte_results.delete();
    if (st) begin
      p_store  = '0;
      p_fill   = '0;
      p_phase  = PH_WIDTH;
      p_width  = '0;
      p_height = '0;
      p_offx   = '0;
      p_offy   = '0;
      p_adv    = '0;
      p_col    = '0;
      p_row    = '0;
      p_zlen   = '0;
      p_olen   = '0;
      p_done   = 1'b0;
    end
    if (p_done) return 1'b0;
    p_store = p_store | (16'(b) << p_fill[3:0]);
    p_fill  = p_fill + 5'd8;
    while (!p_done) begin
      w = phase_width();
      if (p_fill < w) break;
      v = int'(p_store) & ((1 << w) - 1);
      p_store = p_store >> w;
      p_fill  = p_fill - 5'(w);
      case (p_phase)
        PH_WIDTH: begin
          p_width = 8'(v);
          p_phase = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          p_height = 8'(v);
          p_phase  = PH_XOFF;
        end
        PH_XOFF: begin
          p_offx  = unbias(v, w);
          p_phase = PH_YOFF;
        end
        PH_YOFF: begin
          p_offy  = unbias(v, w);
          p_phase = PH_ADV;
        end
        PH_ADV: begin
          p_adv = unbias(v, w);
          add_result(KIND_HEADER, 1'b0, 0, 8'd0, 8'd0);
          if (p_width == 0) close_glyph();
          else p_phase = PH_ZERO;
        end
        PH_ZERO: begin
          p_zlen = 8'(v);
          paint_run(1'b0, v);
          p_phase = PH_ONE;
        end
        PH_ONE: begin
          p_olen = 8'(v);
          paint_run(1'b1, v);
          p_phase = PH_REPEAT;
        end
        default: begin
          if (v != 0) begin
            paint_run(1'b0, p_zlen);
            paint_run(1'b1, p_olen);
          end else if (p_row >= p_height) begin
            close_glyph();
          end else begin
            p_phase = PH_ZERO;
          end
        end
      endcase
    end
    if (byte_results.size() > 0) byte_results[$].last = 1'b1;
    return 1'b1;
  endfunction

  function automatic string show(glyph_res_t r);
    return $sformatf("kind=%0d colour=%0d len=%0d col=%0d row=%0d w=%0d h=%0d %s",
                     r.kind, r.color, r.len, r.col, r.row, r.width, r.height,
                     $sformatf("ox=%0d oy=%0d adv=%0d last=%0d", $signed(r.offx),
                               $signed(r.offy), $signed(r.adv), r.last));
  endfunction

  function automatic string diff_fields(glyph_res_t a, glyph_res_t b);
    string s;
    s = "";
    if (a.kind !== b.kind) s = {s, " kind"};
    if (a.color !== b.color) s = {s, " colour"};
    if (a.len !== b.len) s = {s, " length"};
    if (a.col !== b.col) s = {s, " column"};
    if (a.row !== b.row) s = {s, " row"};
    if (a.width !== b.width) s = {s, " width"};
    if (a.height !== b.height) s = {s, " height"};
    if (a.offx !== b.offx) s = {s, " offset_x"};
    if (a.offy !== b.offy) s = {s, " offset_y"};
    if (a.adv !== b.adv) s = {s, " advance"};
    if (a.last !== b.last) s = {s, " last"};
    return s;
  endfunction

  always @(posedge clk) begin : result_check
    glyph_res_t got, want;
    string      bad;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind   = kind_t'(out_tuser);
      got.color  = out_tdata[0];
      got.len    = out_tdata[8:1];
      got.col    = out_tdata[16:9];
      got.row    = out_tdata[24:17];
      got.width  = out_tdata[32:25];
      got.height = out_tdata[40:33];
      got.offx   = out_tdata[48:41];
      got.offy   = out_tdata[56:49];
      got.adv    = out_tdata[64:57];
      got.last   = out_tlast;
      n_results++;
      if (pending_results.size() == 0) begin
        n_fail++;
        if (n_fail <= REPORT_LIMIT) $display("Unexpected result: %s", show(got));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        bad  = diff_fields(want, got);
        if (bad != "") begin
          n_fail++;
          if (n_fail <= REPORT_LIMIT) begin
            $display("Mismatch on%s", bad);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

  function automatic glyph_res_t fixed_res(kind_t k, logic [7:0] w, logic [7:0] h,
                                           logic [7:0] ox, logic [7:0] oy,
                                           logic [7:0] adv, logic last);
    glyph_res_t r;
    r = '0;
    r.kind   = k;
    r.width  = w;
    r.height = h;
    r.offx   = ox;
    r.offy   = oy;
    r.adv    = adv;
    r.last   = last;
    return r;
  endfunction

  function automatic plan_row_t byte_row(logic [7:0] d, logic st);
    plan_row_t p;
    p       = '0;
    p.op    = ROW_BYTE;
    p.data  = d;
    p.start = st;
    return p;
  endfunction

  function automatic plan_row_t typed_row(logic [7:0] d, logic st, logic [1:0] n,
                                          glyph_res_t r0, glyph_res_t r1);
    plan_row_t p;
    p         = byte_row(d, st);
    p.typed   = 1'b1;
    p.n_typed = n;
    p.r0      = r0;
    p.r1      = r1;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(cfg_idx_t i, logic [3:0] v);
    plan_row_t p;
    p       = '0;
    p.op    = ROW_CFG;
    p.idx   = i;
    p.value = v;
    return p;
  endfunction

  function automatic void add_row(plan_row_t p);
    directed_plan.insert(directed_plan.size(), p);
  endfunction

  task automatic drain_all();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    dirty = 1'b0;
  endtask

  task automatic write_reg(cfg_idx_t i, logic [3:0] v);
    if (dirty) drain_all();
    cfg_we    <= 1'b1;
    cfg_index <= i;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_shadow[i] = v;
    n_writes++;
  endtask

  task automatic put_byte(logic [7:0] b, logic st, logic use_model);
    if (cfg_we) cfg_we <= 1'b0;
    while (!full_rate && $urandom_range(0, 99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= st;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (decode_glyph_byte(b, st)) n_counted++;
    else n_ignored++;
    if (st) n_glyphs++;
    if (use_model) begin
      foreach (byte_results[k]) queue_expected(byte_results[k]);
    end
    dirty = 1'b1;
  endtask

  task automatic random_setting(int k);
    logic [3:0] v;
    for (int i = 0; i < NUM_CFG; i++) begin
      if (k == 0) v = CFG_RESET[i];
      else if (k == 1) v = 4'd15;
      else if (cfg_idx_t'(i) == CFG_HEIGHT) v = 4'($urandom_range(1, 3));
      else if ($urandom_range(0, 9) == 0) v = 4'($urandom_range(0, 15));
      else v = 4'($urandom_range(1, 5));
      write_reg(cfg_idx_t'(i), v);
    end
  endtask

  task automatic build_plan();
    add_row(typed_row(8'hA5, 1'b0, 2'd0, '0, '0));
    add_row(cfg_row(CFG_ZERO_RUN, 4'd1));
    add_row(cfg_row(CFG_ONE_RUN, 4'd1));
    add_row(cfg_row(CFG_WIDTH, 4'd0));
    add_row(cfg_row(CFG_HEIGHT, 4'd1));
    add_row(cfg_row(CFG_XOFF, 4'd1));
    add_row(cfg_row(CFG_YOFF, 4'd1));
    add_row(cfg_row(CFG_ADVANCE, 4'd1));
    // Zero width: header then end straight away.
    add_row(typed_row(8'h00, 1'b1, 2'd2,
      fixed_res(KIND_HEADER, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0),
      fixed_res(KIND_END, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1)));
    add_row(typed_row(8'h1E, 1'b1, 2'd2,
      fixed_res(KIND_HEADER, 8'd0, 8'd1, 8'h00, 8'h00, 8'h00, 1'b0),
      fixed_res(KIND_END, 8'd0, 8'd1, 8'h00, 8'h00, 8'h00, 1'b1)));
    add_row(typed_row(8'hFF, 1'b0, 2'd0, '0, '0));
    // Repeated run pairs, a byte full of repeats, then the end.
    add_row(byte_row(8'hFB, 1'b1));
    add_row(byte_row(8'hFF, 1'b0));
    add_row(byte_row(8'h00, 1'b0));
    // Zero height with a nonzero width still decodes one pair.
    add_row(byte_row(8'h61, 1'b1));
    add_row(cfg_row(CFG_ZERO_RUN, 4'd8));
    add_row(cfg_row(CFG_ONE_RUN, 4'd8));
    add_row(cfg_row(CFG_WIDTH, 4'd8));
    add_row(cfg_row(CFG_HEIGHT, 4'd8));
    add_row(cfg_row(CFG_XOFF, 4'd8));
    add_row(cfg_row(CFG_YOFF, 4'd8));
    add_row(cfg_row(CFG_ADVANCE, 4'd15));
    // Widest header fields at their extremes, then an abandoned glyph.
    add_row(byte_row(8'hFF, 1'b1));
    add_row(byte_row(8'hFF, 1'b0));
    add_row(byte_row(8'h00, 1'b0));
    add_row(byte_row(8'hFF, 1'b0));
    add_row(byte_row(8'h80, 1'b0));
    add_row(byte_row(8'hFF, 1'b0));
    add_row(byte_row(8'h01, 1'b0));
    add_row(byte_row(8'h00, 1'b0));
    add_row(cfg_row(CFG_WIDTH, 4'd1));
    add_row(cfg_row(CFG_HEIGHT, 4'd1));
    add_row(cfg_row(CFG_XOFF, 4'd1));
    add_row(cfg_row(CFG_YOFF, 4'd1));
    add_row(cfg_row(CFG_ADVANCE, 4'd1));
    // Long runs in a one-pixel-wide glyph drive the row into saturation.
    add_row(byte_row(8'hFF, 1'b1));
    add_row(byte_row(8'hFF, 1'b0));
    add_row(byte_row(8'hFF, 1'b0));
    add_row(byte_row(8'hFF, 1'b0));
    add_row(byte_row(8'h00, 1'b0));
  endtask

  initial begin : stimulus
    plan_row_t p;
    int        glyph_len, pick, setting, next_setting, k;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    full_rate  = 1'b0;
    dirty      = 1'b0;
    foreach (cfg_shadow[i]) cfg_shadow[i] = CFG_RESET[i];
    void'(decode_glyph_byte(8'h00, 1'b1));
    p_done = 1'b1;
    p_phase = PH_WIDTH;
    byte_results.delete();
    build_plan();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      p = directed_plan[i];
      if (p.op == ROW_CFG) begin
        write_reg(p.idx, p.value);
      end else begin
        put_byte(p.data, p.start, !p.typed);
        if (p.typed && p.n_typed >= 1) queue_expected(p.r0);
        if (p.typed && p.n_typed >= 2) queue_expected(p.r1);
      end
    end

    setting = 0;
    next_setting = n_counted;
    while (n_counted + n_ignored < RANDOM_ITEMS) begin
      if (n_counted >= next_setting) begin
        random_setting(setting);
        setting++;
        next_setting = n_counted + SETTING_SPAN;
      end
      full_rate = (n_counted >= 140 && n_counted < 220);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        if (p_done) put_byte(8'($urandom), 1'b0, 1'b1);
      end else begin
        glyph_len = (pick < 20) ? $urandom_range(1, 3) : $urandom_range(4, 28);
        put_byte(8'($urandom), 1'b1, 1'b1);
        k = 1;
        while (!p_done && k < glyph_len) begin
          put_byte(8'($urandom), 1'b0, 1'b1);
          k++;
        end
      end
    end
    full_rate = 1'b0;

    drain_all();
    $display("Sent %0d decoded bytes over %0d glyphs plus %0d ignored bytes; %0d results.",
             n_counted, n_glyphs, n_ignored, n_results);
    $display("Covered %0d register writes across %0d random settings, with stalls on both sides.",
             n_writes, setting);
    if (n_fail == 0) begin
      $display("glyph_rle_bitmap_decoder test passed");
    end else begin
      $display("%0d mismatches in total.", n_fail);
      $display("glyph_rle_bitmap_decoder test failed");
    end
    $finish;
  end

endmodule
